@@ design/bts_pkg.sv @@
package bts_pkg;

    // Default width of all time values; times wrap modulo 2^TIME_BITS.
    localparam int TIME_BITS_DEFAULT = 32;

    // Number of bump and touch switches.
    localparam int NUM_TOUCH = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_STEERING_TRIM = 3'd0;
    localparam logic [2:0] REG_CRUISE_MS     = 3'd1;
    localparam logic [2:0] REG_BACKOFF_MS    = 3'd2;
    localparam logic [2:0] REG_TURN_MS       = 3'd3;
    localparam logic [2:0] REG_LOCKOUT_US    = 3'd4;
    localparam logic [2:0] REG_DRIVE_LEVEL   = 3'd5;

    // Configuration values after reset.
    localparam logic signed [5:0] TRIM_RESET     = 6'sd10;
    localparam logic [15:0]       CRUISE_RESET   = 16'd15000;
    localparam logic [15:0]       BACKOFF_RESET  = 16'd800;
    localparam logic [15:0]       TURN_RESET     = 16'd800;
    localparam logic [19:0]       LOCKOUT_RESET  = 20'd10000;
    localparam logic [7:0]        DRIVE_RESET    = 8'd255;

    // Steering angle after reset: straight ahead plus the reset trim.
    localparam logic [7:0] STEER_CENTRE = 8'd90;
    localparam logic [7:0] STEER_RESET  = 8'(90 + 10);
    localparam logic [7:0] STEER_MAX    = 8'd180;

    // Headings for straight runs and for turns.
    localparam logic signed [7:0] HEADING_AHEAD = 8'sd0;
    localparam logic signed [7:0] HEADING_LEFT  = -8'sd60;
    localparam logic signed [7:0] HEADING_RIGHT = 8'sd60;

    // Robot modes.
    localparam logic [3:0] MODE_INIT       = 4'd0;
    localparam logic [3:0] MODE_RESET      = 4'd1;
    localparam logic [3:0] MODE_RUN        = 4'd2;
    localparam logic [3:0] MODE_BACKWARD   = 4'd3;
    localparam logic [3:0] MODE_IDLE       = 4'd4;
    localparam logic [3:0] MODE_FWD_LEFT   = 4'd5;
    localparam logic [3:0] MODE_FWD_RIGHT  = 4'd6;
    localparam logic [3:0] MODE_LEFT       = 4'd7;
    localparam logic [3:0] MODE_RIGHT      = 4'd8;
    localparam logic [3:0] MODE_BACK_LEFT  = 4'd9;
    localparam logic [3:0] MODE_BACK_RIGHT = 4'd10;
    localparam logic [3:0] MODE_FORWARD    = 4'd11;

    // Helm manoeuvres.
    localparam logic [2:0] MOVE_IDLE   = 3'd0;
    localparam logic [2:0] MOVE_AHEAD  = 3'd1;
    localparam logic [2:0] MOVE_BACK   = 3'd2;
    localparam logic [2:0] MOVE_TURN_L = 3'd3;
    localparam logic [2:0] MOVE_TURN_R = 3'd4;

    // Lamp patterns.
    localparam logic [2:0] LAMP_OFF   = 3'd0;
    localparam logic [2:0] LAMP_ON    = 3'd1;
    localparam logic [2:0] LAMP_SLOW  = 3'd2;
    localparam logic [2:0] LAMP_FAST  = 3'd3;
    localparam logic [2:0] LAMP_SHORT = 3'd4;

    // Lamp pattern phases in microseconds.
    localparam logic [31:0] SLOW_ON_US  = 32'd600000;
    localparam logic [31:0] SLOW_OFF_US = 32'd200000;
    localparam logic [31:0] FAST_ON_US  = 32'd100000;
    localparam logic [31:0] FAST_OFF_US = 32'd100000;
    localparam logic [31:0] SHORT_ON_US = 32'd400000;

    // Milliseconds to microseconds.
    localparam logic [31:0] US_PER_MS = 32'd1000;

    // Configuration registers as seen by the sequencing logic.
    typedef struct packed {
        logic signed [5:0] steering_trim;
        logic [15:0]       cruise_ms;
        logic [15:0]       backoff_ms;
        logic [15:0]       turn_ms;
        logic [19:0]       lockout_us;
        logic [7:0]        drive_level;
    } cfg_t;

    // Held drive, steering and lamp levels after one tick.
    typedef struct packed {
        logic       bump_lamp;
        logic       status_lamp;
        logic [7:0] steer_angle;
        logic [7:0] right_rev_pwm;
        logic [7:0] right_fwd_pwm;
        logic [7:0] left_rev_pwm;
        logic [7:0] left_fwd_pwm;
    } res_t;

endpackage

@@ design/bts_step.sv @@
module bts_step #(
    parameter int TIME_BITS = bts_pkg::TIME_BITS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [31:0]   time_us,
    input  logic [4:0]    levels,
    input  bts_pkg::cfg_t cfg,
    output bts_pkg::res_t res
);
    import bts_pkg::*;

    localparam int XW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic LAMP_STATUS = 1'b0;
    localparam logic LAMP_BUMP   = 1'b1;

    typedef logic [TIME_BITS-1:0] tm_t;

    typedef struct packed {
        logic [3:0]                robot_mode;
        logic [2:0]                helm_mode;
        tm_t                       helm_start;
        tm_t                       helm_span;
        logic [4:0]                switch_prev;
        logic [NUM_TOUCH-1:0][TIME_BITS-1:0] last_act;
        logic [1:0][2:0]           lamp_setting;
        logic [1:0]                lamp_lit;
        logic [1:0][TIME_BITS-1:0] lamp_mark;
        logic [1:0][TIME_BITS-1:0] lamp_on;
        logic [1:0][TIME_BITS-1:0] lamp_off;
        logic [3:0][7:0]           pwm;
        logic [7:0]                steer;
    } st_t;

    st_t st_reg;
    st_t st_next;

    // Milliseconds to wrapped microseconds.
    function automatic tm_t ms_to_us(input logic [15:0] ms);
        logic [31:0] prod;
        prod = 32'(ms) * US_PER_MS;
        return tm_t'(prod);
    endfunction

    // Heading plus centre plus trim, saturated to the servo range.
    function automatic logic [7:0] steer_calc(input logic signed [7:0] heading,
                                              input logic signed [5:0] trim);
        logic signed [9:0] a;
        a = 10'(heading) + 10'sd90 + 10'(trim);
        if (a < 10'sd0) begin
            return 8'd0;
        end else if (a > 10'sd180) begin
            return STEER_MAX;
        end
        return a[7:0];
    endfunction

    // Select a lamp pattern and restart its phase at the tick time.
    function automatic st_t lamp_set(input st_t s, input logic k, input logic [2:0] code,
                                     input tm_t t);
        st_t r;
        r = s;
        r.lamp_setting[k] = code;
        r.lamp_mark[k] = '0;
        if (code == LAMP_OFF) begin
            r.lamp_lit[k] = 1'b0;
        end else begin
            r.lamp_lit[k] = 1'b1;
            r.lamp_mark[k] = t;
            if (code == LAMP_SLOW) begin
                r.lamp_on[k]  = tm_t'(SLOW_ON_US);
                r.lamp_off[k] = tm_t'(SLOW_OFF_US);
            end else if (code == LAMP_FAST) begin
                r.lamp_on[k]  = tm_t'(FAST_ON_US);
                r.lamp_off[k] = tm_t'(FAST_OFF_US);
            end else begin
                r.lamp_on[k] = tm_t'(SHORT_ON_US);
            end
        end
        return r;
    endfunction

    // Advance one lamp pattern; deadlines compare against the wrapped sum.
    function automatic st_t lamp_tick(input st_t s, input logic k, input tm_t t);
        st_t r;
        tm_t on_end;
        tm_t off_end;
        r = s;
        on_end  = s.lamp_mark[k] + s.lamp_on[k];
        off_end = s.lamp_mark[k] + s.lamp_off[k];
        if (s.lamp_setting[k] == LAMP_SHORT) begin
            if (s.lamp_lit[k] && t > on_end) begin
                r.lamp_lit[k] = 1'b0;
            end
        end else if (s.lamp_setting[k] == LAMP_SLOW || s.lamp_setting[k] == LAMP_FAST) begin
            if (!s.lamp_lit[k]) begin
                if (t > off_end) begin
                    r.lamp_lit[k]  = 1'b1;
                    r.lamp_mark[k] = t;
                end
            end else if (t > on_end) begin
                r.lamp_lit[k]  = 1'b0;
                r.lamp_mark[k] = t;
            end
        end
        return r;
    endfunction

    // Start a timed manoeuvre: latch the span, steer and set the bridges.
    function automatic st_t helm_begin(input st_t s, input logic [2:0] h, input tm_t span,
                                       input logic signed [7:0] heading, input tm_t t,
                                       input cfg_t c);
        st_t r;
        logic [7:0] v;
        r = s;
        v = c.drive_level;
        r.helm_mode  = h;
        r.helm_start = t;
        r.helm_span  = span;
        r.steer      = steer_calc(heading, c.steering_trim);
        case (h)
            MOVE_AHEAD:  r.pwm = {8'd0, v, 8'd0, v};
            MOVE_BACK:   r.pwm = {v, 8'd0, v, 8'd0};
            MOVE_TURN_L: r.pwm = {8'd0, 8'd0, 8'd0, v};
            default:     r.pwm = {8'd0, v, 8'd0, 8'd0};
        endcase
        return r;
    endfunction

    // Straight run forward or backward with the status lamp steady.
    function automatic st_t go_straight(input st_t s, input logic fwd, input tm_t span,
                                        input tm_t t, input cfg_t c);
        st_t r;
        r = s;
        r.robot_mode = fwd ? MODE_FORWARD : MODE_BACKWARD;
        r = helm_begin(r, fwd ? MOVE_AHEAD : MOVE_BACK, span, HEADING_AHEAD, t, c);
        r = lamp_set(r, LAMP_STATUS, LAMP_ON, t);
        return r;
    endfunction

    // Turn left or right with the status lamp flashing fast.
    function automatic st_t go_turn(input st_t s, input logic left, input tm_t t,
                                    input cfg_t c);
        st_t r;
        r = s;
        r.robot_mode = left ? MODE_LEFT : MODE_RIGHT;
        r = helm_begin(r, left ? MOVE_TURN_L : MOVE_TURN_R, ms_to_us(c.turn_ms),
                       left ? HEADING_LEFT : HEADING_RIGHT, t, c);
        r = lamp_set(r, LAMP_STATUS, LAMP_FAST, t);
        return r;
    endfunction

    // Follow-up once the current manoeuvre has run its span.
    function automatic st_t helm_done(input st_t s, input tm_t t, input cfg_t c);
        st_t r;
        r = s;
        case (s.robot_mode)
            MODE_FORWARD, MODE_BACKWARD: begin
                r.helm_mode  = MOVE_IDLE;
                r.helm_start = '0;
                r.helm_span  = '0;
                r.steer      = steer_calc(HEADING_AHEAD, c.steering_trim);
                r.pwm        = '0;
                r.robot_mode = MODE_IDLE;
            end
            MODE_FWD_LEFT, MODE_BACK_LEFT:   r = go_turn(r, 1'b1, t, c);
            MODE_FWD_RIGHT, MODE_BACK_RIGHT: r = go_turn(r, 1'b0, t, c);
            MODE_LEFT, MODE_RIGHT:           r = go_straight(r, 1'b1, ms_to_us(c.cruise_ms), t, c);
            default: ;
        endcase
        return r;
    endfunction

    // Escape from a bump: rear switches drive forward, front switches reverse,
    // then turn away from the side that was hit.
    function automatic st_t touched(input st_t s, input logic [1:0] idx, input tm_t t,
                                    input cfg_t c);
        st_t r;
        r = lamp_set(s, LAMP_BUMP, LAMP_SHORT, t);
        r = go_straight(r, !idx[1], ms_to_us(c.backoff_ms), t, c);
        case (idx)
            2'd0:    r.robot_mode = MODE_FWD_RIGHT;
            2'd1:    r.robot_mode = MODE_FWD_LEFT;
            2'd2:    r.robot_mode = MODE_BACK_RIGHT;
            default: r.robot_mode = MODE_BACK_LEFT;
        endcase
        return r;
    endfunction

    // Whole tick in one pass: button, switches, helm timer, lamps, mode work.
    always_comb begin
        st_t s;
        tm_t t;
        tm_t gap;
        tm_t elapsed;
        s = st_reg;
        t = tm_t'(time_us);
        gap = '0;
        elapsed = t - s.helm_start;

        if (levels[0] != s.switch_prev[0]) begin
            s.switch_prev[0] = levels[0];
            s = lamp_set(s, LAMP_STATUS, LAMP_OFF, t);
            s.robot_mode = levels[0] ? MODE_RUN : MODE_RESET;
        end

        for (int i = 0; i < NUM_TOUCH; i++) begin
            if (levels[i+1] != s.switch_prev[i+1]) begin
                s.switch_prev[i+1] = levels[i+1];
                if (!levels[i+1]) begin
                    gap = t - s.last_act[i];
                    if (XW'(gap) > XW'(cfg.lockout_us) || t < s.last_act[i]) begin
                        s = touched(s, 2'(i), t, cfg);
                        s.last_act[i] = t;
                    end
                end
            end
        end

        if (s.helm_mode >= MOVE_AHEAD && s.helm_mode <= MOVE_TURN_R) begin
            elapsed = t - s.helm_start;
            if (elapsed >= s.helm_span) begin
                s.helm_mode = MOVE_IDLE;
                s = helm_done(s, t, cfg);
            end
        end

        s = lamp_tick(s, LAMP_STATUS, t);
        s = lamp_tick(s, LAMP_BUMP, t);

        if (s.robot_mode == MODE_RESET) begin
            s.steer = steer_calc(HEADING_AHEAD, cfg.steering_trim);
            s = lamp_set(s, LAMP_STATUS, LAMP_OFF, t);
        end else if (s.robot_mode == MODE_RUN) begin
            s = go_straight(s, 1'b1, ms_to_us(cfg.cruise_ms), t, cfg);
        end

        st_next = s;
    end

    // State advances once for every accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.robot_mode   <= MODE_INIT;
            st_reg.helm_mode    <= MOVE_IDLE;
            st_reg.helm_start   <= '0;
            st_reg.helm_span    <= '0;
            st_reg.switch_prev  <= '1;
            st_reg.last_act     <= '0;
            st_reg.lamp_setting <= {LAMP_OFF, LAMP_SLOW};
            st_reg.lamp_lit     <= 2'b01;
            st_reg.lamp_mark    <= '0;
            st_reg.lamp_on      <= {tm_t'(0), tm_t'(SLOW_ON_US)};
            st_reg.lamp_off     <= {tm_t'(0), tm_t'(SLOW_OFF_US)};
            st_reg.pwm          <= '0;
            st_reg.steer        <= STEER_RESET;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

    // Levels reported for the word being accepted.
    always_comb begin
        res.left_fwd_pwm  = st_next.pwm[0];
        res.left_rev_pwm  = st_next.pwm[1];
        res.right_fwd_pwm = st_next.pwm[2];
        res.right_rev_pwm = st_next.pwm[3];
        res.steer_angle   = st_next.steer;
        res.status_lamp   = st_next.lamp_lit[0];
        res.bump_lamp     = st_next.lamp_lit[1];
    end

endmodule

@@ design/bump_and_turn_drive_sequencer.sv @@
// Channel  | Direction | Payload
// ---------+-----------+----------------------------------------------------------
// s_       | in        | tick: time_us, reset and four switch levels
// m_       | out       | four bridge PWM levels, steering angle, two lamp levels
// cfg_     | in        | register index and write data
//
// One tick is taken in every cycle that the output register is empty or being
// emptied; its result is ready in the next cycle, in the output register, after
// a single pass through the sequencing logic. Reset is synchronous and active
// low; it loads the power-up modes and the reset values of all but m_data_reg.
// A stalled output holds its word and stops the input only while it is full
// and not taken, so a word can enter in the cycle the previous one leaves.
module bump_and_turn_drive_sequencer #(
    parameter int TIME_BITS = bts_pkg::TIME_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // time_us[31:0], reset_level, rear_left_level, rear_right_level,
    // front_left_level, front_right_level, zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_fwd_pwm[7:0], left_rev_pwm[7:0], right_fwd_pwm[7:0],
    // right_rev_pwm[7:0], steer_angle[7:0], status_lamp, bump_lamp, zero fill
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import bts_pkg::*;

    cfg_t        cfg_reg;
    logic        m_valid_reg;
    res_t        m_data_reg;
    res_t        res;
    logic        accept;

    // The register file is always ready.
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steering_trim <= TRIM_RESET;
            cfg_reg.cruise_ms     <= CRUISE_RESET;
            cfg_reg.backoff_ms    <= BACKOFF_RESET;
            cfg_reg.turn_ms       <= TURN_RESET;
            cfg_reg.lockout_us    <= LOCKOUT_RESET;
            cfg_reg.drive_level   <= DRIVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STEERING_TRIM: cfg_reg.steering_trim <= cfg_data[5:0];
                REG_CRUISE_MS:     cfg_reg.cruise_ms     <= cfg_data[15:0];
                REG_BACKOFF_MS:    cfg_reg.backoff_ms    <= cfg_data[15:0];
                REG_TURN_MS:       cfg_reg.turn_ms       <= cfg_data[15:0];
                REG_LOCKOUT_US:    cfg_reg.lockout_us    <= cfg_data;
                REG_DRIVE_LEVEL:   cfg_reg.drive_level   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // A word enters whenever the output register is empty or being emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bts_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .time_us (s_tdata[31:0]),
        .levels  (s_tdata[36:32]),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

`ifndef ASSERT_OFF
    // An empty output register never holds back the input.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    // Every accepted word leaves a result in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn) accept |=> m_valid_reg)
        else $error("accepted word produced no result");

    // The steering angle stays within the servo range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.steer_angle <= STEER_MAX)
        else $error("steering angle out of range");

    // No bridge is driven forward and reverse at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.left_fwd_pwm != 8'd0 && m_data_reg.left_rev_pwm != 8'd0)
                     && !(m_data_reg.right_fwd_pwm != 8'd0
                          && m_data_reg.right_rev_pwm != 8'd0))
        else $error("bridge driven both ways");
`endif

endmodule
